// ===== hdl/csu_pkg.sv =====
`timescale 1ns / 1ps

package csu_pkg;

	// Field and accumulator widths.
	localparam int unsigned ELEM_W = 16;
	localparam int unsigned ACC_W  = 48;
	localparam int unsigned LIMB_W = 32;
	localparam int unsigned PROD_W = 64;
	localparam int unsigned WIDE_W = 128;
	localparam int unsigned Q_W    = 15;

	// One in Q1.14, the top of the search range.
	localparam logic [Q_W-1:0] ONE_Q14 = 15'd16384;

	// Saturation limits of the sums.
	localparam logic [ACC_W-1:0] DOT_MAX  = 48'h7FFF_FFFF_FFFF;
	localparam logic [ACC_W-1:0] DOT_MIN  = 48'h8000_0000_0000;
	localparam logic [ACC_W-1:0] NORM_MAX = 48'hFFFF_FFFF_FFFF;

	// Sequencer states.
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_ACC  = 8'b0000_0010,
		ST_PREP = 8'b0000_0100,
		ST_SQD  = 8'b0000_1000,
		ST_PRD  = 8'b0001_0000,
		ST_SRCH = 8'b0010_0000,
		ST_KSQ  = 8'b0100_0000,
		ST_TMUL = 8'b1000_0000
	} state_t;

	// Limb position at which a partial product joins the wide accumulator.
	typedef enum logic [1:0] {
		SH_0  = 2'd0,
		SH_32 = 2'd1,
		SH_64 = 2'd2
	} shift_t;

endpackage

// ===== hdl/cosine_similarity_unit.sv =====
`timescale 1ns / 1ps

// Streaming cosine similarity of two vectors given one element pair per item.
// Input channel: drive element_a, element_b (signed Q3.12) and last_element
// with start high; the item is taken at a rising edge where start is high and
// busy is low. Busy stays high while a pair is processed, so a new pair is
// taken only once the block is through with the last one; the single shared
// 32x32 multiplier forms a*b, a*a and b*b one after another.
// Output channel: on the item marked last, done pulses for one cycle with
// similarity (signed Q1.14, clipped to +-1.0) and degenerate. When either sum
// of squares is zero the zero-norm check gives the result with degenerate
// set and similarity 0. Otherwise the same multiplier squares |dot|, forms
// the product of the two norms and runs a binary search of 14 to 15 steps,
// each squaring 2*mid-1 and scaling the norm product by that square.
// The sums are cleared after every result. Sums saturate when no last mark
// comes. The receiver has no way to stall: done flags the result for one
// cycle only.
// Reset (arst_n low) clears the sums and returns the sequencer to idle.
module cosine_similarity_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [csu_pkg::ELEM_W-1:0]   element_a,
	input  logic signed [csu_pkg::ELEM_W-1:0]   element_b,
	input  logic                                last_element,
	output logic                                done,
	output logic signed [csu_pkg::ELEM_W-1:0]   similarity,
	output logic                                degenerate
);
	import csu_pkg::*;

	state_t                 state_q;
	logic [2:0]             step_q;

	logic [ELEM_W-1:0]      mag_a_q;
	logic [ELEM_W-1:0]      mag_b_q;
	logic                   neg_ab_q;
	logic                   last_q;

	logic [ACC_W-1:0]       dot_q;
	logic [ACC_W-1:0]       na_q;
	logic [ACC_W-1:0]       nb_q;

	logic [LIMB_W-1:0]      mul_x;
	logic [LIMB_W-1:0]      mul_y;
	logic [PROD_W-1:0]      mul_p;
	logic [PROD_W-1:0]      prod_q;
	logic                   iss_v;
	shift_t                 iss_sh;
	logic                   add_v_q;
	shift_t                 add_sh_q;

	logic [WIDE_W-1:0]      acc_q;
	logic [WIDE_W-1:0]      acc_term;
	logic [WIDE_W-1:0]      acc_sum;

	logic [62:0]            d_q;
	logic [WIDE_W-1:0]      d2_q;
	logic [95:0]            p_q;
	logic [29:0]            k_q;
	logic                   dot_neg_q;

	logic [Q_W-1:0]         lo_q;
	logic [Q_W-1:0]         hi_q;
	logic [Q_W-1:0]         mid_q;
	logic [Q_W:0]           mid_sum;
	logic [Q_W:0]           m2;
	logic [Q_W:0]           q_ext;

	logic [ELEM_W-1:0]      abs_a;
	logic [ELEM_W-1:0]      abs_b;
	logic [ACC_W-1:0]       dot_mag;
	logic signed [ACC_W:0]  dot_term;
	logic signed [ACC_W:0]  dot_wide;
	logic [ACC_W-1:0]       dot_next;
	logic [ACC_W-1:0]       norm_in;
	logic [ACC_W:0]         norm_wide;
	logic [ACC_W-1:0]       norm_next;

	assign busy = (state_q != ST_IDLE);

	// Magnitudes of the incoming elements; -32768 maps to 32768.
	assign abs_a = element_a[ELEM_W-1] ? (~element_a + 1'b1) : element_a;
	assign abs_b = element_b[ELEM_W-1] ? (~element_b + 1'b1) : element_b;

	// Signed dot product update with saturation to 48 bits.
	assign dot_term = neg_ab_q ? -$signed({18'b0, prod_q[30:0]})
	                           : $signed({18'b0, prod_q[30:0]});
	assign dot_wide = $signed({dot_q[ACC_W-1], dot_q}) + dot_term;
	always_comb begin
		if (dot_wide[ACC_W] != dot_wide[ACC_W-1]) begin
			dot_next = dot_wide[ACC_W] ? DOT_MIN : DOT_MAX;
		end else begin
			dot_next = dot_wide[ACC_W-1:0];
		end
	end

	// One saturating adder serves both sums of squares.
	assign norm_in   = (step_q == 3'd2) ? na_q : nb_q;
	assign norm_wide = {1'b0, norm_in} + {18'b0, prod_q[30:0]};
	assign norm_next = norm_wide[ACC_W] ? NORM_MAX : norm_wide[ACC_W-1:0];

	assign dot_mag = dot_q[ACC_W-1] ? (~dot_q + 1'b1) : dot_q;

	// Search midpoint and the odd factor 2*mid-1 whose square scales the norms.
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + 16'd1;
	assign m2      = {mid_q, 1'b0} - 16'd1;
	assign q_ext   = {1'b0, lo_q};

	// Operand selection for the shared multiplier, per state and step.
	always_comb begin
		mul_x  = '0;
		mul_y  = '0;
		iss_v  = 1'b0;
		iss_sh = SH_0;
		case (state_q)
			ST_ACC: begin
				case (step_q)
					3'd0: begin
						mul_x = {16'b0, mag_a_q};
						mul_y = {16'b0, mag_b_q};
					end
					3'd1: begin
						mul_x = {16'b0, mag_a_q};
						mul_y = {16'b0, mag_a_q};
					end
					3'd2: begin
						mul_x = {16'b0, mag_b_q};
						mul_y = {16'b0, mag_b_q};
					end
					default: ;
				endcase
			end
			ST_SQD: begin
				case (step_q)
					3'd0: begin
						mul_x = d_q[31:0];
						mul_y = d_q[31:0];
						iss_v = 1'b1;
					end
					3'd1: begin
						mul_x  = d_q[31:0];
						mul_y  = {1'b0, d_q[62:32]};
						iss_v  = 1'b1;
						iss_sh = SH_32;
					end
					3'd2: begin
						mul_x  = {1'b0, d_q[62:32]};
						mul_y  = d_q[31:0];
						iss_v  = 1'b1;
						iss_sh = SH_32;
					end
					3'd3: begin
						mul_x  = {1'b0, d_q[62:32]};
						mul_y  = {1'b0, d_q[62:32]};
						iss_v  = 1'b1;
						iss_sh = SH_64;
					end
					default: ;
				endcase
			end
			ST_PRD: begin
				case (step_q)
					3'd0: begin
						mul_x = na_q[31:0];
						mul_y = nb_q[31:0];
						iss_v = 1'b1;
					end
					3'd1: begin
						mul_x  = na_q[31:0];
						mul_y  = {16'b0, nb_q[47:32]};
						iss_v  = 1'b1;
						iss_sh = SH_32;
					end
					3'd2: begin
						mul_x  = {16'b0, na_q[47:32]};
						mul_y  = nb_q[31:0];
						iss_v  = 1'b1;
						iss_sh = SH_32;
					end
					3'd3: begin
						mul_x  = {16'b0, na_q[47:32]};
						mul_y  = {16'b0, nb_q[47:32]};
						iss_v  = 1'b1;
						iss_sh = SH_64;
					end
					default: ;
				endcase
			end
			ST_KSQ: begin
				if (step_q == 3'd0) begin
					mul_x = {16'b0, m2};
					mul_y = {16'b0, m2};
				end
			end
			ST_TMUL: begin
				case (step_q)
					3'd0: begin
						mul_x = p_q[31:0];
						mul_y = {2'b0, k_q};
						iss_v = 1'b1;
					end
					3'd1: begin
						mul_x  = p_q[63:32];
						mul_y  = {2'b0, k_q};
						iss_v  = 1'b1;
						iss_sh = SH_32;
					end
					3'd2: begin
						mul_x  = p_q[95:64];
						mul_y  = {2'b0, k_q};
						iss_v  = 1'b1;
						iss_sh = SH_64;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign mul_p = mul_x * mul_y;

	// Registered product, then placement into the wide accumulator.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
	end

	always_comb begin
		case (add_sh_q)
			SH_0:    acc_term = {64'b0, prod_q};
			SH_32:   acc_term = {32'b0, prod_q, 32'b0};
			SH_64:   acc_term = {prod_q, 64'b0};
			default: acc_term = '0;
		endcase
	end

	assign acc_sum = acc_q + (add_v_q ? acc_term : '0);

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			done       <= 1'b0;
			similarity <= '0;
			degenerate <= 1'b0;
			mag_a_q    <= '0;
			mag_b_q    <= '0;
			neg_ab_q   <= 1'b0;
			last_q     <= 1'b0;
			dot_q      <= '0;
			na_q       <= '0;
			nb_q       <= '0;
			add_v_q    <= 1'b0;
			add_sh_q   <= SH_0;
			acc_q      <= '0;
			d_q        <= '0;
			d2_q       <= '0;
			p_q        <= '0;
			k_q        <= '0;
			dot_neg_q  <= 1'b0;
			lo_q       <= '0;
			hi_q       <= '0;
			mid_q      <= '0;
		end else begin
			// The strobe follows the zero-norm check or the closed search.
			done     <= ((state_q == ST_PREP) && (na_q == '0 || nb_q == '0))
			         || ((state_q == ST_SRCH) && (lo_q == hi_q));
			add_v_q  <= iss_v;
			add_sh_q <= iss_sh;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						mag_a_q  <= abs_a;
						mag_b_q  <= abs_b;
						neg_ab_q <= element_a[ELEM_W-1] ^ element_b[ELEM_W-1];
						last_q   <= last_element;
						step_q   <= '0;
						state_q  <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (step_q == 3'd1) begin
						dot_q <= dot_next;
					end
					if (step_q == 3'd2) begin
						na_q <= norm_next;
					end
					if (step_q == 3'd3) begin
						nb_q    <= norm_next;
						step_q  <= '0;
						state_q <= last_q ? ST_PREP : ST_IDLE;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_PREP: begin
					// A zero sum of squares gives the degenerate result at once.
					if (na_q == '0 || nb_q == '0) begin
						degenerate <= 1'b1;
						similarity <= '0;
						dot_q      <= '0;
						na_q       <= '0;
						nb_q       <= '0;
						state_q    <= ST_IDLE;
					end else begin
						d_q       <= {dot_mag, 15'b0};
						dot_neg_q <= dot_q[ACC_W-1];
						acc_q     <= '0;
						step_q    <= '0;
						state_q   <= ST_SQD;
					end
				end
				ST_SQD: begin
					if (step_q == 3'd4) begin
						d2_q    <= acc_sum;
						acc_q   <= '0;
						step_q  <= '0;
						state_q <= ST_PRD;
					end else begin
						acc_q  <= acc_sum;
						step_q <= step_q + 3'd1;
					end
				end
				ST_PRD: begin
					if (step_q == 3'd4) begin
						p_q     <= acc_sum[95:0];
						acc_q   <= '0;
						step_q  <= '0;
						lo_q    <= '0;
						hi_q    <= ONE_Q14;
						state_q <= ST_SRCH;
					end else begin
						acc_q  <= acc_sum;
						step_q <= step_q + 3'd1;
					end
				end
				ST_SRCH: begin
					// The search has closed: lo is the rounded magnitude.
					if (lo_q == hi_q) begin
						degenerate <= 1'b0;
						similarity <= dot_neg_q ? $signed(-q_ext) : $signed(q_ext);
						dot_q      <= '0;
						na_q       <= '0;
						nb_q       <= '0;
						state_q    <= ST_IDLE;
					end else begin
						mid_q   <= mid_sum[Q_W:1];
						step_q  <= '0;
						state_q <= ST_KSQ;
					end
				end
				ST_KSQ: begin
					if (step_q == 3'd1) begin
						k_q     <= prod_q[29:0];
						step_q  <= '0;
						state_q <= ST_TMUL;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_TMUL: begin
					// Keep mid when P*(2*mid-1)^2 does not exceed (|dot|*2^15)^2.
					if (step_q == 3'd3) begin
						if (acc_sum <= d2_q) begin
							lo_q <= mid_q;
						end else begin
							hi_q <= mid_q - 15'd1;
						end
						acc_q   <= '0;
						step_q  <= '0;
						state_q <= ST_SRCH;
					end else begin
						acc_q  <= acc_sum;
						step_q <= step_q + 3'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// A result only leaves the search end or the zero-norm check.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_SRCH || $past(state_q) == ST_PREP))
		else $error("result strobe from an unexpected state");

	// A degenerate result always carries a zero similarity.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (similarity == '0))
		else $error("degenerate result with nonzero similarity");

	// The similarity never leaves plus or minus one.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (similarity <= 16'sd16384 && similarity >= -16'sd16384))
		else $error("similarity out of range");

	// An accepted item always starts the accumulation steps.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_ACC && step_q == 3'd0))
		else $error("accepted item did not enter accumulation");

	// The search bounds never cross.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (lo_q <= hi_q))
		else $error("search bounds crossed");
`endif

endmodule
